### src/h2r_pkg.sv
`default_nettype none

package h2r_pkg;

  // Percent limit for saturation and value.
  localparam logic [6:0]  PCT_MAX     = 7'd100;
  // Hue codes per sector and the full-scale level numerator (255 * 100).
  localparam logic [10:0] HUE_SPAN    = 11'd255;
  localparam logic [14:0] LEVEL_FULL  = 15'd25500;
  // Rounding for the divide by 10000: bias, divisor and reciprocal.
  localparam logic [21:0] ROUND_BIAS  = 22'd5000;
  localparam logic [21:0] DIV_DEN     = 22'd10000;
  localparam logic [32:0] RECIP_M     = 33'd1677;
  localparam int          RECIP_SHIFT = 24;

  // Channel levels, one lane each.
  localparam int NUM_LANES = 4;
  localparam int LANE_V    = 0;
  localparam int LANE_P    = 1;
  localparam int LANE_Q    = 2;
  localparam int LANE_T    = 3;

  typedef logic [14:0] span_t;
  typedef logic [21:0] num_t;
  typedef logic [32:0] prod_t;

  // Color circle sectors, named by the hue range each one covers.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  // Front end result: value and the four level spans, before scaling by value.
  typedef struct packed {
    logic                        valid;
    sector_t                     sector;
    logic [6:0]                  v;
    span_t [NUM_LANES-1:0]       span;
  } front_t;

  // Scaled numerators and their reciprocal products.
  typedef struct packed {
    logic                        valid;
    sector_t                     sector;
    num_t  [NUM_LANES-1:0]       num;
    prod_t [NUM_LANES-1:0]       prod;
  } scale_t;

endpackage

`default_nettype wire

### src/h2r_front.sv
`default_nettype none

module h2r_front import h2r_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire hsv_word_t in_word,
  output front_t         front_o
);

  // Stage one: clamp percentages, split hue into sector and fraction.
  logic       s1_valid_r;
  sector_t    s1_sector_r;
  logic [7:0] s1_frac_r;
  logic [6:0] s1_s_r;
  logic [6:0] s1_v_r;

  logic [6:0]  sat_c;
  logic [6:0]  val_c;
  logic [10:0] h6;
  logic [2:0]  raw_sec;
  logic [10:0] sec_base;
  logic [7:0]  frac_c;
  sector_t     sector_c;

  always_comb begin
    sat_c = (in_word.saturation > 8'(PCT_MAX)) ? PCT_MAX : in_word.saturation[6:0];
    val_c = (in_word.brightness > 8'(PCT_MAX)) ? PCT_MAX : in_word.brightness[6:0];
    h6    = 11'(in_word.hue) * 11'd6;
    raw_sec = 3'(h6 >= HUE_SPAN) + 3'(h6 >= 11'd510) + 3'(h6 >= 11'd765)
            + 3'(h6 >= 11'd1020) + 3'(h6 >= 11'd1275) + 3'(h6 >= 11'd1530);
    sec_base = 11'(raw_sec) * HUE_SPAN;
    frac_c   = 8'(h6 - sec_base);
    // The top hue code lands in a seventh sector; it folds onto the last one.
    sector_c = (raw_sec > 3'(SEC_MR)) ? SEC_MR : sector_t'(raw_sec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sector_r <= sector_c;
    s1_frac_r   <= frac_c;
    s1_s_r      <= sat_c;
    s1_v_r      <= val_c;
  end

  // Stage two: the spans 25500 - S*F and friends, ready to scale by value.
  front_t     front_r;
  front_t     front_nxt;
  logic [7:0] inv_frac;
  span_t      s_f;
  span_t      s_inv;

  always_comb begin
    inv_frac  = 8'd255 - s1_frac_r;
    s_f       = 15'(s1_s_r) * 15'(s1_frac_r);
    s_inv     = 15'(s1_s_r) * 15'(inv_frac);
    front_nxt.valid          = s1_valid_r;
    front_nxt.sector         = s1_sector_r;
    front_nxt.v              = s1_v_r;
    front_nxt.span[LANE_V]   = LEVEL_FULL;
    front_nxt.span[LANE_P]   = 15'(PCT_MAX - s1_s_r) * 15'd255;
    front_nxt.span[LANE_Q]   = LEVEL_FULL - s_f;
    front_nxt.span[LANE_T]   = LEVEL_FULL - s_inv;
  end

  // Only the valid bit is reset; the data fields simply follow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r.valid <= front_nxt.valid;
    end
    front_r.sector <= front_nxt.sector;
    front_r.v      <= front_nxt.v;
    front_r.span   <= front_nxt.span;
  end

  assign front_o = front_r;

  // Every span stays within full scale, so no level can exceed 255.
  assert property (@(posedge clk) disable iff (!rst_n)
    front_r.valid |-> (front_r.span[LANE_P] <= LEVEL_FULL &&
                       front_r.span[LANE_Q] <= LEVEL_FULL &&
                       front_r.span[LANE_T] <= LEVEL_FULL))
    else $error("h2r_front: level span above full scale");

endmodule

`default_nettype wire

### src/h2r_scale.sv
`default_nettype none

module h2r_scale import h2r_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire front_t front_i,
  output scale_t      scale_o
);

  // Stage three: scale each span by value and add the rounding bias.
  logic                  s3_valid_r;
  sector_t               s3_sector_r;
  num_t [NUM_LANES-1:0]  s3_num_r;
  num_t [NUM_LANES-1:0]  s3_num_nxt;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      s3_num_nxt[i] = 22'(front_i.v) * 22'(front_i.span[i]) + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= front_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_sector_r <= front_i.sector;
    s3_num_r    <= s3_num_nxt;
  end

  // Stage four: multiply by the reciprocal of 10000 for a quotient estimate.
  scale_t                scale_r;
  prod_t [NUM_LANES-1:0] prod_nxt;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod_nxt[i] = 33'(s3_num_r[i]) * RECIP_M;
    end
  end

  // Only the valid bit is reset; the data fields simply follow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r.valid <= 1'b0;
    end else begin
      scale_r.valid <= s3_valid_r;
    end
    scale_r.sector <= s3_sector_r;
    scale_r.num    <= s3_num_r;
    scale_r.prod   <= prod_nxt;
  end

  assign scale_o = scale_r;

endmodule

`default_nettype wire

### src/h2r_round.sv
`default_nettype none

module h2r_round import h2r_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire scale_t scale_i,
  output logic        out_valid,
  output rgb_word_t   out_word
);

  // The estimate is at most one low; one compare against the remainder fixes it.
  logic [8:0]                 q_est  [NUM_LANES];
  num_t                       q_back [NUM_LANES];
  num_t                       q_rem  [NUM_LANES];
  logic [NUM_LANES-1:0][7:0]  level;
  logic                       rem_ok;

  always_comb begin
    rem_ok = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      q_est[i]  = scale_i.prod[i][RECIP_SHIFT+8:RECIP_SHIFT];
      q_back[i] = 22'(q_est[i]) * DIV_DEN;
      q_rem[i]  = scale_i.num[i] - q_back[i];
      level[i]  = 8'(q_est[i] + 9'(q_rem[i] >= DIV_DEN));
      rem_ok    = rem_ok && (q_rem[i] < (DIV_DEN + DIV_DEN));
    end
  end

  // Pick the level for each channel by sector.
  rgb_word_t out_word_r;
  rgb_word_t out_word_nxt;
  logic      out_valid_r;

  always_comb begin
    case (scale_i.sector)
      SEC_RY: begin
        out_word_nxt = '{level[LANE_V], level[LANE_T], level[LANE_P]};
      end
      SEC_YG: begin
        out_word_nxt = '{level[LANE_Q], level[LANE_V], level[LANE_P]};
      end
      SEC_GC: begin
        out_word_nxt = '{level[LANE_P], level[LANE_V], level[LANE_T]};
      end
      SEC_CB: begin
        out_word_nxt = '{level[LANE_P], level[LANE_Q], level[LANE_V]};
      end
      SEC_BM: begin
        out_word_nxt = '{level[LANE_T], level[LANE_P], level[LANE_V]};
      end
      default: begin
        out_word_nxt = '{level[LANE_V], level[LANE_P], level[LANE_Q]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= scale_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The reciprocal estimate must never be off by more than one.
  assert property (@(posedge clk) disable iff (!rst_n)
    scale_i.valid |-> rem_ok)
    else $error("h2r_round: quotient estimate needs more than one correction");

endmodule

`default_nettype wire

### src/hsv_to_rgb_converter.sv
// A color taken at a clock edge is registered by each stage in turn and shows on out_word
// with out_valid once the rounding stage has registered it.
// Throughput: one color per clock; busy stays low, so start may be held high every cycle.
// The five stages are clamp and sector split, span products, value scaling,
// reciprocal product, and rounding with channel select.
// Reset (rst_n low, synchronous) clears the valid bits; words in flight are dropped.
`default_nettype none

module hsv_to_rgb_converter import h2r_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire hsv_word_t in_word,
  output logic           out_valid,
  output rgb_word_t      out_word
);

  front_t front;
  scale_t scale;
  logic   accept;

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  h2r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_word  (in_word),
    .front_o  (front)
  );

  h2r_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .front_i (front),
    .scale_o (scale)
  );

  h2r_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale_i   (scale),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Every result word traces back to an input word taken earlier.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("hsv_to_rgb_converter: result word without a matching input word");

endmodule

`default_nettype wire
